// File: rtl/sdf_pkg.sv
package sdf_pkg;

  // width of one display position code
  localparam int DIGIT_W = 4;

  // width of the dot mask field on the input
  localparam int DOT_W = 6;

  // display code for the minus sign
  localparam logic [DIGIT_W-1:0] MINUS_CODE = 4'd10;

  // status of the iterative converter
  typedef struct packed {
    logic busy;
    logic done;
    logic ovf;
  } conv_stat_t;

endpackage

// File: rtl/sdf_bcd_unit.sv
// iterative shift and add-3 binary to bcd converter, one bit per cycle
module sdf_bcd_unit #(
  parameter int NUM_POSITIONS = 6,
  parameter int VALUE_BITS    = 32
) (
  input  logic                                           clk,
  input  logic                                           rst_n,
  input  logic                                           start,
  input  logic [VALUE_BITS-1:0]                          mag,
  output logic [NUM_POSITIONS-1:0][sdf_pkg::DIGIT_W-1:0] digits,
  output sdf_pkg::conv_stat_t                            stat
);

  localparam int CNT_W = $clog2(VALUE_BITS + 1);
  localparam int BCD_W = NUM_POSITIONS * sdf_pkg::DIGIT_W;

  logic [VALUE_BITS-1:0] mag_r, mag_nxt;
  logic [BCD_W-1:0]      bcd_r, bcd_nxt;
  logic [BCD_W-1:0]      bcd_adj;
  logic                  ovf_r, ovf_nxt;
  logic [CNT_W-1:0]      cnt_r, cnt_nxt;
  logic                  busy_r, busy_nxt;
  logic                  done_r, done_nxt;

  // add-3 correction on every digit at or above five
  always_comb begin
    for (int k = 0; k < NUM_POSITIONS; k++) begin
      if (bcd_r[k*sdf_pkg::DIGIT_W +: sdf_pkg::DIGIT_W] >= 4'd5) begin
        bcd_adj[k*sdf_pkg::DIGIT_W +: sdf_pkg::DIGIT_W] =
          bcd_r[k*sdf_pkg::DIGIT_W +: sdf_pkg::DIGIT_W] + 4'd3;
      end else begin
        bcd_adj[k*sdf_pkg::DIGIT_W +: sdf_pkg::DIGIT_W] =
          bcd_r[k*sdf_pkg::DIGIT_W +: sdf_pkg::DIGIT_W];
      end
    end
  end

  // sequencer for the shift steps
  always_comb begin
    mag_nxt  = mag_r;
    bcd_nxt  = bcd_r;
    ovf_nxt  = ovf_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      mag_nxt  = mag;
      bcd_nxt  = '0;
      ovf_nxt  = 1'b0;
      cnt_nxt  = CNT_W'(VALUE_BITS);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      // a carry out of the top digit means more digits than positions
      ovf_nxt = ovf_r | bcd_adj[BCD_W-1];
      bcd_nxt = {bcd_adj[BCD_W-2:0], mag_r[VALUE_BITS-1]};
      mag_nxt = {mag_r[VALUE_BITS-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
    ovf_r <= ovf_nxt;
  end

  assign digits    = bcd_r;
  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign stat.ovf  = ovf_r;

endmodule

// File: rtl/signed_decimal_display_formatter.sv
// Signed decimal display formatter. Each input word carries a signed number and a
// dot mask and yields one output word of right-aligned digit codes for a row of
// NUM_POSITIONS seven-segment positions (position 0 leftmost), with leading positions
// blanked, a lone 0 for zero and the minus code just left of the top digit when a
// position is free for it. Magnitudes too long for the row keep their low digits,
// all lit, with no sign. The magnitude runs through a shift and add-3 converter one
// bit per cycle; a new word is accepted only once the previous result has gone into
// the output register, and in_tready is high only while the converter is free. A
// result may wait in the output register while a new word is accepted; a finished
// result that finds the output register still full waits in the converter, and no
// new word is accepted until it has moved on.
module signed_decimal_display_formatter #(
  parameter int NUM_POSITIONS = 6,
  parameter int VALUE_BITS    = 32
) (
  input  logic clk,
  input  logic rst_n,
  // in_tdata: value [VALUE_BITS-1:0], dot_mask [5:0], zero fill
  input  logic in_tvalid,
  output logic in_tready,
  input  logic [((VALUE_BITS + sdf_pkg::DOT_W + 7) / 8) * 8 - 1:0] in_tdata,
  // out_tdata: digit_pos0 .. digit_pos(N-1) 4 bits each, lit_mask, point_mask, zero fill
  output logic out_tvalid,
  input  logic out_tready,
  output logic [((NUM_POSITIONS * sdf_pkg::DIGIT_W + 2 * NUM_POSITIONS + 7) / 8) * 8 - 1:0]
               out_tdata
);

  localparam int IN_BITS  = VALUE_BITS + sdf_pkg::DOT_W;
  localparam int DIG_BITS = NUM_POSITIONS * sdf_pkg::DIGIT_W;
  localparam int OUT_BITS = DIG_BITS + 2 * NUM_POSITIONS;
  localparam int OUT_TW   = ((OUT_BITS + 7) / 8) * 8;
  localparam int DW_W     = NUM_POSITIONS + sdf_pkg::DOT_W;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CONV = 2'd1;
  localparam logic [1:0] ST_HOLD = 2'd2;

  logic [1:0] state_r, state_nxt;

  logic [VALUE_BITS-1:0]       in_value;
  logic [sdf_pkg::DOT_W-1:0]   in_dots;
  logic [DW_W-1:0]             dots_wide;
  logic [VALUE_BITS-1:0]       in_mag;
  logic                        in_acc;

  logic                        neg_r;
  logic [NUM_POSITIONS-1:0]    dots_r;

  logic [NUM_POSITIONS-1:0][sdf_pkg::DIGIT_W-1:0] digits;
  sdf_pkg::conv_stat_t                            stat;

  logic [NUM_POSITIONS-1:0][sdf_pkg::DIGIT_W-1:0] codes;
  logic [NUM_POSITIONS-1:0]                       lit;

  logic                     out_valid_r, out_valid_nxt;
  logic [OUT_TW-1:0]        out_data_r;
  logic                     load;

  // input unpacking and magnitude
  assign in_value  = in_tdata[VALUE_BITS-1:0];
  assign in_dots   = in_tdata[IN_BITS-1:VALUE_BITS];
  assign dots_wide = DW_W'(in_dots);
  assign in_mag    = in_value[VALUE_BITS-1] ? (~in_value + 1'b1) : in_value;
  assign in_tready = (state_r == ST_IDLE);
  assign in_acc    = in_tvalid && in_tready;

  sdf_bcd_unit #(
    .NUM_POSITIONS (NUM_POSITIONS),
    .VALUE_BITS    (VALUE_BITS)
  ) u_bcd (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (in_acc),
    .mag    (in_mag),
    .digits (digits),
    .stat   (stat)
  );

  // blanking and sign placement; digit k weighs 10^k and sits at position N-1-k
  always_comb begin
    int top;
    int cnt;
    top = 0;
    for (int k = 0; k < NUM_POSITIONS; k++) begin
      if (digits[k] != '0) top = k;
    end
    cnt = stat.ovf ? NUM_POSITIONS : top + 1;
    for (int i = 0; i < NUM_POSITIONS; i++) begin
      if (i >= NUM_POSITIONS - cnt) begin
        codes[i] = digits[NUM_POSITIONS-1-i];
        lit[i]   = 1'b1;
      end else if (neg_r && (i == NUM_POSITIONS - cnt - 1)) begin
        codes[i] = sdf_pkg::MINUS_CODE;
        lit[i]   = 1'b1;
      end else begin
        codes[i] = '0;
        lit[i]   = 1'b0;
      end
    end
  end

  // sequencer
  assign load = ((state_r == ST_CONV && stat.done) || state_r == ST_HOLD) &&
                (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_acc) state_nxt = ST_CONV;
      end
      ST_CONV: begin
        if (stat.done) state_nxt = load ? ST_IDLE : ST_HOLD;
      end
      ST_HOLD: begin
        if (load) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output register valid
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (load) out_valid_nxt = 1'b1;
    else if (out_tready) out_valid_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item side data and result word
  always_ff @(posedge clk) begin
    if (in_acc) begin
      neg_r  <= in_value[VALUE_BITS-1];
      dots_r <= dots_wide[NUM_POSITIONS-1:0];
    end
    if (load) begin
      out_data_r <= OUT_TW'({dots_r, lit, codes});
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

endmodule
